// ===== src/pi_speed_controller_antiwindup_unit_defines.svh =====
// Assertion macros shared by the checker of the PI speed controller.
// No dependencies; included by the checker file only.
`ifndef PI_SPEED_CONTROLLER_ANTIWINDUP_UNIT_DEFINES_SVH
`define PI_SPEED_CONTROLLER_ANTIWINDUP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PISC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pisc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PISC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pisc assertion failed");

`endif

// ===== src/pisc_pkg.sv =====
// Shared types and constants of the PI speed controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pisc_pkg;

  // Field and register widths.
  localparam int TGT_W  = 8;
  localparam int MEAS_W = 10;
  localparam int ERR_W  = 11;
  localparam int GAIN_W = 20;
  localparam int SP_W   = 16;
  localparam int LIM_W  = 8;
  localparam int DRV_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Multiplier operand and product widths.
  localparam int MA_W = ERR_W + SP_W;      // error times sample period
  localparam int MB_W = GAIN_W + 1;        // unsigned gain with a sign bit
  localparam int MP_W = MA_W + MB_W;
  localparam int P_W  = ERR_W + MB_W;      // proportional term

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN     = 20'd655360;
  localparam logic [GAIN_W-1:0] RST_INTEG_GAIN    = 20'd196608;
  localparam logic [SP_W-1:0]   RST_SAMPLE_PERIOD = 16'd1311;
  localparam logic [LIM_W-1:0]  RST_OUTPUT_LIMIT  = 8'd255;

  // Multiplier operand selection.
  localparam logic [1:0] MUL_PROP = 2'd0;
  localparam logic [1:0] MUL_TERM = 2'd1;
  localparam logic [1:0] MUL_INC  = 2'd2;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [SP_W-1:0]   sample_period;
    logic [LIM_W-1:0]  output_limit;
  } cfg_t;

  typedef struct packed {
    logic       ld_in;
    logic [1:0] mul_sel;
    logic       ld_p;
    logic       ld_t;
    logic       ld_prod;
    logic       ld_en;
    logic       upd_integ;
    logic       ld_out;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
  } sts_t;

endpackage

// ===== src/pisc_cfg.sv =====
// Configuration register file of the PI speed controller.
// Depends on pisc_pkg.
`timescale 1ns / 1ps

module pisc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pisc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pisc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pisc_pkg::cfg_t                     cfg
);

  pisc_pkg::cfg_t cfg_r;
  pisc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pisc_pkg::REG_PROP_GAIN:     cfg_nxt.prop_gain = cfg_data;
        pisc_pkg::REG_INTEG_GAIN:    cfg_nxt.integ_gain = cfg_data;
        pisc_pkg::REG_SAMPLE_PERIOD: cfg_nxt.sample_period = cfg_data[pisc_pkg::SP_W-1:0];
        pisc_pkg::REG_OUTPUT_LIMIT:  cfg_nxt.output_limit = cfg_data[pisc_pkg::LIM_W-1:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= pisc_pkg::RST_PROP_GAIN;
      cfg_r.integ_gain    <= pisc_pkg::RST_INTEG_GAIN;
      cfg_r.sample_period <= pisc_pkg::RST_SAMPLE_PERIOD;
      cfg_r.output_limit  <= pisc_pkg::RST_OUTPUT_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/pisc_ctrl.sv =====
// Sequencing state machine of the PI speed controller.
// Depends on pisc_pkg; drives the datapath through cmd_t.
`timescale 1ns / 1ps

module pisc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pisc_pkg::sts_t sts,
  output pisc_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROP  = 3'd1;
  localparam logic [2:0] S_TERM  = 3'd2;
  localparam logic [2:0] S_INC   = 3'd3;
  localparam logic [2:0] S_INTEG = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mul_sel   = pisc_pkg::MUL_PROP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = sts.in_zero ? S_OUT : S_PROP;
        end
      end
      S_PROP: begin
        cmd.mul_sel = pisc_pkg::MUL_PROP;
        cmd.ld_p    = 1'b1;
        state_nxt   = S_TERM;
      end
      S_TERM: begin
        cmd.mul_sel = pisc_pkg::MUL_TERM;
        cmd.ld_t    = 1'b1;
        cmd.ld_en   = 1'b1;
        state_nxt   = S_INC;
      end
      S_INC: begin
        cmd.mul_sel = pisc_pkg::MUL_INC;
        cmd.ld_prod = 1'b1;
        state_nxt   = S_INTEG;
      end
      S_INTEG: begin
        cmd.upd_integ = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        // The result register must be empty or emptying before it is reloaded.
        if (!out_valid_r || out_ready) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== src/pisc_dp.sv =====
// Arithmetic datapath of the PI speed controller: shared multiplier,
// integral register with anti-windup and output rounding. Depends on pisc_pkg.
`timescale 1ns / 1ps

module pisc_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pisc_pkg::cfg_t                  cfg,
  input  pisc_pkg::cmd_t                  cmd,
  output pisc_pkg::sts_t                  sts,
  input  logic [pisc_pkg::TGT_W-1:0]      in_target_rpm,
  input  logic [pisc_pkg::MEAS_W-1:0]     in_measured_rpm,
  output logic [pisc_pkg::DRV_W-1:0]      out_drive
);

  localparam int INT_W = pisc_pkg::LIM_W + FRAC_BITS;
  localparam int PRE_W = pisc_pkg::P_W + 1;
  localparam int SUM_W = pisc_pkg::MP_W + 1;
  localparam logic [INT_W-1:0] HALF = INT_W'(1) << (FRAC_BITS - 1);

  logic signed [pisc_pkg::ERR_W-1:0] err_r;
  logic                              zero_r;
  logic signed [pisc_pkg::P_W-1:0]   p_r;
  logic signed [pisc_pkg::MA_W-1:0]  t_r;
  logic signed [pisc_pkg::MP_W-1:0]  prod_r;
  logic                              en_r;
  logic [INT_W-1:0]                  integ_r;
  logic [INT_W-1:0]                  integ_nxt;
  logic [pisc_pkg::DRV_W-1:0]        drive_r;
  logic [pisc_pkg::DRV_W-1:0]        drive_nxt;

  logic signed [pisc_pkg::ERR_W-1:0] err_in;
  logic signed [pisc_pkg::MA_W-1:0]  mul_a;
  logic signed [pisc_pkg::MB_W-1:0]  mul_b;
  logic signed [pisc_pkg::MP_W-1:0]  prod;
  logic [INT_W-1:0]                  maxq;
  logic signed [PRE_W-1:0]           maxq_pre;
  logic signed [SUM_W-1:0]           maxq_sum;
  logic signed [PRE_W-1:0]           pre;
  logic                              high;
  logic                              low;
  logic                              en;
  logic signed [pisc_pkg::MP_W-1:0]  inc;
  logic signed [SUM_W-1:0]           sum;
  logic signed [PRE_W-1:0]           fin;
  logic [INT_W-1:0]                  fin_clamp;
  logic [INT_W:0]                    rnd;

  assign err_in = $signed({1'b0, in_target_rpm}) - $signed({1'b0, in_measured_rpm});
  assign sts.in_zero = (in_target_rpm == '0);

  // One signed multiplier serves all three products.
  always_comb begin
    unique case (cmd.mul_sel)
      pisc_pkg::MUL_PROP: begin
        mul_a = pisc_pkg::MA_W'(err_r);
        mul_b = $signed({1'b0, cfg.prop_gain});
      end
      pisc_pkg::MUL_TERM: begin
        mul_a = pisc_pkg::MA_W'(err_r);
        mul_b = pisc_pkg::MB_W'($signed({1'b0, cfg.sample_period}));
      end
      pisc_pkg::MUL_INC: begin
        mul_a = t_r;
        mul_b = $signed({1'b0, cfg.integ_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign maxq     = {cfg.output_limit, {FRAC_BITS{1'b0}}};
  assign maxq_pre = PRE_W'($signed({1'b0, maxq}));
  assign maxq_sum = SUM_W'($signed({1'b0, maxq}));

  // Conditional integration: inside the range, or saturated and the error
  // points back toward it.
  assign pre  = PRE_W'(p_r) + PRE_W'($signed({1'b0, integ_r}));
  assign high = pre > maxq_pre;
  assign low  = pre < 0;
  assign en   = (!high && !low) || (high && err_r < 0) || (low && err_r > 0);

  // The arithmetic shift floors a negative increment.
  always_comb begin
    inc = '0;
    if (en_r) begin
      inc = prod_r >>> FRAC_BITS;
    end
  end

  assign sum = SUM_W'(inc) + SUM_W'($signed({1'b0, integ_r}));

  always_comb begin
    integ_nxt = integ_r;
    if (cmd.upd_integ) begin
      priority if (sum > maxq_sum) integ_nxt = maxq;
      else if (sum < 0)            integ_nxt = '0;
      else                         integ_nxt = sum[INT_W-1:0];
    end else if (cmd.ld_out && zero_r) begin
      integ_nxt = '0;
    end
  end

  assign fin = PRE_W'(p_r) + PRE_W'($signed({1'b0, integ_r}));

  always_comb begin
    priority if (fin < 0)   fin_clamp = '0;
    else if (fin > maxq_pre) fin_clamp = maxq;
    else                     fin_clamp = fin[INT_W-1:0];
  end

  // Round half up; the clamp keeps the quotient within the drive width.
  assign rnd       = {1'b0, fin_clamp} + {1'b0, HALF};
  assign drive_nxt = zero_r ? '0 : rnd[FRAC_BITS +: pisc_pkg::DRV_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      err_r  <= err_in;
      zero_r <= sts.in_zero;
    end
    if (cmd.ld_p) begin
      p_r <= prod[pisc_pkg::P_W-1:0];
    end
    if (cmd.ld_t) begin
      t_r <= prod[pisc_pkg::MA_W-1:0];
    end
    if (cmd.ld_en) begin
      en_r <= en;
    end
    if (cmd.ld_prod) begin
      prod_r <= prod;
    end
    if (cmd.ld_out) begin
      drive_r <= drive_nxt;
    end
  end

  assign out_drive = drive_r;

endmodule

// ===== src/pi_speed_controller_antiwindup_unit.sv =====
// PI speed controller with conditional-integration anti-windup, top level.
// A request is accepted only in the idle state, once the previous one has made three
// passes through one shared multiplier plus the integral update and output
// rounding steps; a zero target skips to the output step, which a full result register can hold.
// Reset (rst_n, synchronous, active low) clears the integral and the
// handshake state and loads the default gains, sample time and limit.
`timescale 1ns / 1ps

module pi_speed_controller_antiwindup_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pisc_pkg::TGT_W-1:0]      in_target_rpm,
  input  logic [pisc_pkg::MEAS_W-1:0]     in_measured_rpm,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pisc_pkg::DRV_W-1:0]      out_drive,
  input  logic                            cfg_we,
  input  logic [pisc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pisc_pkg::CFG_DATA_W-1:0] cfg_data
);

  // The controller walks each request through the steps below:
  //   accept   - latch the speed error and the zero-target flag.
  //   prop     - multiplier forms the proportional term gain * error.
  //   term     - multiplier forms error * sample time; in parallel the
  //              pre-sum P + I is checked against the limits to decide
  //              whether the integral may move.
  //   inc      - multiplier forms the scaled increment with the integral gain.
  //   integ    - the floored increment is added when allowed and the
  //              integral is clamped to the output range.
  //   out      - P + I is clamped, rounded half up and loaded into the
  //              result register once it is free.
  // A zero target skips straight to the output step, which then clears the
  // integral and drives zero. The result register lets a finished request
  // wait for the consumer while the next request is accepted.

  pisc_pkg::cfg_t cfg;
  pisc_pkg::cmd_t cmd;
  pisc_pkg::sts_t sts;

  pisc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pisc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pisc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .in_target_rpm   (in_target_rpm),
    .in_measured_rpm (in_measured_rpm),
    .out_drive       (out_drive)
  );

endmodule

// ===== src/pisc_checker.sv =====
// Port-level assertions for the PI speed controller, bound to the top level.
// Depends on pisc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "pi_speed_controller_antiwindup_unit_defines.svh"

module pisc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [pisc_pkg::TGT_W-1:0]      in_target_rpm,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [pisc_pkg::DRV_W-1:0]      out_drive
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // Leaving reset, nothing is pending and a request can be taken.
  `PISC_ASSERT_NOW(a_reset_state, clk, rst_n, $rose(rst_n), !out_valid && in_ready)

  // Only one request is in flight at a time.
  `PISC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_acc, !in_ready)

  // A nonzero target runs through all arithmetic steps before the next request.
  `PISC_ASSERT_NEXT(a_full_compute, clk, rst_n, in_acc && (in_target_rpm != '0), !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)

  // A stalled result is held.
  `PISC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_drive))

endmodule

bind pi_speed_controller_antiwindup_unit pisc_checker u_pisc_checker (.*);

// ===== tb/sv/pi_speed_controller_antiwindup_unit_test.sv =====
// Self-checking testbench for the PI speed controller with anti-windup.
// Depends on pisc_pkg and pi_speed_controller_antiwindup_unit; predicts every
// drive value in place and scores the results as they leave the block.
`timescale 1ns / 1ps

module pi_speed_controller_antiwindup_unit_test;

  // The block runs with its default fraction width; the predictor matches it.
  localparam int FRAC_BITS   = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 20;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [pisc_pkg::TGT_W-1:0]      in_target_rpm = '0;
  logic [pisc_pkg::MEAS_W-1:0]     in_measured_rpm = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [pisc_pkg::DRV_W-1:0]      out_drive;
  logic                            cfg_we = 1'b0;
  logic [pisc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pisc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pi_speed_controller_antiwindup_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_target_rpm  (in_target_rpm),
    .in_measured_rpm(in_measured_rpm),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_drive      (out_drive),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the controller: the four settings and the integral.
  // The settings start at the block's reset values and follow every write.
  logic [pisc_pkg::GAIN_W-1:0] prop_gain_q     = pisc_pkg::RST_PROP_GAIN;
  logic [pisc_pkg::GAIN_W-1:0] integ_gain_q    = pisc_pkg::RST_INTEG_GAIN;
  logic [pisc_pkg::SP_W-1:0]   sample_period_q = pisc_pkg::RST_SAMPLE_PERIOD;
  logic [pisc_pkg::LIM_W-1:0]  output_limit_q  = pisc_pkg::RST_OUTPUT_LIMIT;
  logic [23:0]                 integ_shadow    = '0;

  // Drive values still owed by the block, oldest first.
  logic [pisc_pkg::DRV_W-1:0] drive_expected[$];

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int hold_requests   = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int settings_used   = 1;
  int mismatch_count  = 0;
  int cycle_count     = 0;

  // Computes the drive value for one request and advances the integral.
  // Everything is carried in 64-bit signed arithmetic, so nothing wraps;
  // the increment is floored by an arithmetic shift.
  function automatic logic [pisc_pkg::DRV_W-1:0] predict_drive(
      input logic [pisc_pkg::TGT_W-1:0]  target,
      input logic [pisc_pkg::MEAS_W-1:0] measured);
    longint error, prop, step, acc, presum, total, ceiling;
    logic   above, below;
    if (target == '0) begin
      // A stop request clears the integral and drives nothing.
      integ_shadow = '0;
      return '0;
    end
    ceiling = longint'(output_limit_q) <<< FRAC_BITS;
    error   = longint'(target) - longint'(measured);
    prop    = longint'(prop_gain_q) * error;
    step    = (error * longint'(sample_period_q) * longint'(integ_gain_q)) >>> FRAC_BITS;
    acc     = longint'(integ_shadow);
    presum  = prop + acc;
    above   = presum > ceiling;
    below   = presum < 0;
    // Integrate only inside the range (bounds included), or when the error
    // pulls a saturated sum back toward the range.
    if ((!above && !below) || (above && error < 0) || (below && error > 0))
      acc = acc + step;
    if (acc > ceiling)
      acc = ceiling;
    if (acc < 0)
      acc = 0;
    integ_shadow = acc[23:0];
    total = prop + acc;
    if (total < 0)
      total = 0;
    if (total > ceiling)
      total = ceiling;
    total = (total + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return total[pisc_pkg::DRV_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [pisc_pkg::DRV_W-1:0] got,
                                 input logic [pisc_pkg::DRV_W-1:0] want);
    $display("ERROR at %0t ns: %s, drive %0d, predicted %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Result checker. It samples at the clock edge, so it sees the values
  // that were in place before the edge, and it pairs each accepted result
  // with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (drive_expected.size() == 0) begin
        report_mismatch("result with no request outstanding", out_drive, '0);
      end else begin
        if (out_drive !== drive_expected[0])
          report_mismatch("drive differs", out_drive, drive_expected[0]);
        void'(drive_expected.pop_front());
      end
      results_checked++;
    end
  end

  // Result receiver. It is ready at random according to recv_idle_pct. A
  // test can ask for a long hold-off by bumping hold_requests; the length of
  // that hold is counted here so the sender keeps offering requests meanwhile.
  int hold_served = 0;
  int hold_left   = 0;
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung block ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, drive_expected.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one request and returns at the edge where it is accepted. Valid
  // is lowered only for idle cycles, so back-to-back requests keep it high.
  // The prediction is made at the acceptance edge with the settings of that
  // moment, which cannot change while requests are in flight.
  task automatic send_request(input logic [pisc_pkg::TGT_W-1:0] target,
                              input logic [pisc_pkg::MEAS_W-1:0] measured);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_target_rpm   <= target;
    in_measured_rpm <= measured;
    do @(posedge clk); while (!in_ready);
    drive_expected.push_back(predict_drive(target, measured));
    requests_sent++;
  endtask

  // Stops offering and waits until every owed result has come back. The
  // block answers every request, so an empty queue means it is idle; the
  // short pause after that only settles the handshake before a write.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (drive_expected.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes one register; the caller lowers the write enable afterwards.
  task automatic write_reg(input logic [pisc_pkg::CFG_IDX_W-1:0] index,
                           input logic [pisc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Loads all four settings in consecutive cycles and mirrors them.
  task automatic apply_settings(input logic [pisc_pkg::GAIN_W-1:0] prop_gain,
                                input logic [pisc_pkg::GAIN_W-1:0] integ_gain,
                                input logic [pisc_pkg::SP_W-1:0] sample_period,
                                input logic [pisc_pkg::LIM_W-1:0] output_limit);
    write_reg(pisc_pkg::REG_PROP_GAIN, prop_gain);
    write_reg(pisc_pkg::REG_INTEG_GAIN, integ_gain);
    write_reg(pisc_pkg::REG_SAMPLE_PERIOD, pisc_pkg::CFG_DATA_W'(sample_period));
    write_reg(pisc_pkg::REG_OUTPUT_LIMIT, pisc_pkg::CFG_DATA_W'(output_limit));
    cfg_we          <= 1'b0;
    prop_gain_q     = prop_gain;
    integ_gain_q    = integ_gain;
    sample_period_q = sample_period;
    output_limit_q  = output_limit;
    settings_used++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Reset settings: a slow approach to a target so the integral climbs,
  // small negative and zero errors, both error extremes, a stop request in
  // the middle, and alternating bit patterns on both fields.
  task automatic test_reset_settings();
    send_request(8'd100, 10'd95);
    send_request(8'd100, 10'd95);
    send_request(8'd100, 10'd95);
    send_request(8'd100, 10'd101);
    send_request(8'd100, 10'd100);
    send_request(8'd255, 10'd0);
    send_request(8'd1, 10'd1023);
    send_request(8'd0, 10'd1023);
    send_request(8'd255, 10'd1023);
    send_request(8'd170, 10'd341);
    wait_until_idle();
  endtask

  // Unity proportional gain with a limit of 50: an error of 50 puts the
  // pre-sum exactly on the upper bound, which still integrates. An odd
  // integral gain makes a negative increment inexact, so its floor shows.
  task automatic test_bound_and_floor();
    apply_settings(20'd65536, 20'd65537, 16'd65535, 8'd50);
    send_request(8'd50, 10'd0);
    send_request(8'd50, 10'd0);
    send_request(8'd10, 10'd11);
    send_request(8'd0, 10'd5);
    send_request(8'd60, 10'd0);
    send_request(8'd1, 10'd2);
    wait_until_idle();
  endtask

  // Extreme settings: a zero limit pins everything at zero even with the
  // largest gains; zero gains with the full limit leave only rounding.
  task automatic test_extreme_settings();
    apply_settings(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 8'd0);
    send_request(8'd255, 10'd0);
    send_request(8'd1, 10'd1023);
    send_request(8'd7, 10'd7);
    wait_until_idle();
    apply_settings(20'd0, 20'd0, 16'd0, 8'd255);
    send_request(8'd200, 10'd100);
    send_request(8'd85, 10'd682);
    wait_until_idle();
  endtask

  // Draws a fresh setting: sometimes the corners, usually gains scaled down
  // by a random shift so that the integral has room to move.
  task automatic pick_settings();
    logic [pisc_pkg::GAIN_W-1:0] prop_gain, integ_gain;
    logic [pisc_pkg::SP_W-1:0]   sample_period;
    logic [pisc_pkg::LIM_W-1:0]  output_limit;
    if ($urandom_range(3) == 0) begin
      prop_gain     = $urandom_range(1) ? 20'hFFFFF : 20'd0;
      integ_gain    = $urandom_range(1) ? 20'hFFFFF : 20'd0;
      sample_period = $urandom_range(1) ? 16'hFFFF : 16'd0;
      output_limit  = $urandom_range(1) ? 8'd255 : 8'd1;
    end else begin
      prop_gain     = pisc_pkg::GAIN_W'($urandom_range(20'hFFFFF) >> $urandom_range(12));
      integ_gain    = pisc_pkg::GAIN_W'($urandom_range(20'hFFFFF) >> $urandom_range(10));
      sample_period = pisc_pkg::SP_W'($urandom_range(16'hFFFF) >> $urandom_range(8));
      output_limit  = pisc_pkg::LIM_W'($urandom_range(255, 1));
    end
    apply_settings(prop_gain, integ_gain, sample_period, output_limit);
  endtask

  // Random traffic. Most requests track a target with the measured speed a
  // little off it, which is how a running loop looks and keeps the integral
  // busy between the bounds; a few stop the motor and the rest are noise
  // over the full field ranges.
  task automatic run_random_requests(input int count);
    int                          kind, offset;
    logic [pisc_pkg::TGT_W-1:0]  target;
    logic [pisc_pkg::MEAS_W-1:0] measured;
    for (int n = 0; n < count; n++) begin
      kind   = $urandom_range(99);
      target = pisc_pkg::TGT_W'($urandom_range(255, 1));
      offset = int'(target) + $urandom_range(40) - 20;
      if (offset < 0)
        offset = 0;
      measured = pisc_pkg::MEAS_W'(offset);
      if (kind < 5)
        target = '0;
      else if (kind >= 80)
        measured = pisc_pkg::MEAS_W'($urandom_range(1023));
      send_request(target, measured);
    end
  endtask

  // One idling profile over several settings, draining between them.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int segments, input int per_segment);
    set_idling(send_pct, recv_pct);
    for (int s = 0; s < segments; s++) begin
      pick_settings();
      run_random_requests(per_segment);
      wait_until_idle();
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming
  // with no gaps, so the block fills up and has to stall its input.
  task automatic test_backpressure();
    set_idling(0, 0);
    apply_settings(pisc_pkg::RST_PROP_GAIN, pisc_pkg::RST_INTEG_GAIN,
                   pisc_pkg::RST_SAMPLE_PERIOD, pisc_pkg::RST_OUTPUT_LIMIT);
    hold_requests <= hold_requests + 1;
    run_random_requests(40);
    wait_until_idle();
  endtask

  initial begin
    // Reset once, with the receiver already running at random.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_bound_and_floor();
    test_extreme_settings();
    test_random_traffic(18, 72, 4, 93);
    test_random_traffic(72, 18, 4, 93);
    test_random_traffic(0, 0, 4, 92);
    test_backpressure();

    // Let any stray result show up before scoring.
    wait_until_idle();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d requests under %0d settings, including a zero limit and a long",
             requests_sent, settings_used);
    $display("output hold-off; %0d results checked, %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0 && drive_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
